>>> rtl/u8d_pkg.sv
// Package: shared input word type and byte-class constants for the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int PARTIAL_W = 15;
   localparam int PEND_W    = 2;
   localparam int CONT_W    = 6;

   localparam logic [BYTE_W-1:0] LEAD_2_LO = 8'hc0;
   localparam logic [BYTE_W-1:0] LEAD_2_HI = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD_3_HI = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD_4_HI = 8'hf7;

   localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
   localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
   localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
   localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

   // Registered input word handed from the input stage to the decoder.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_string;
   } in_word_type;

endpackage

`default_nettype wire

>>> rtl/u8d_if.sv
// Interfaces: byte request channel and code point response channel.
`default_nettype none

interface u8d_req_if
   import u8d_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8d_rsp_if
   import u8d_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            error;
   logic            string_done;

   modport source (output valid, output code_point, output error, output string_done,
                   input ready);
   modport sink   (input valid, input code_point, input error, input string_done,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/u8d_in_stage.sv
// Input register: captures one byte word and holds it until the decoder takes it.
`default_nettype none

module u8d_in_stage
   import u8d_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   u8d_req_if.sink    req_chan,
   input  wire logic  take,
   output in_word_type word
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              eos_ff;
   logic              accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign valid_in       = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.in_byte;
         eos_ff  <= req_chan.end_of_string;
      end
   end

   assign word.valid         = valid_ff;
   assign word.in_byte       = byte_ff;
   assign word.end_of_string = eos_ff;

endmodule

`default_nettype wire

>>> rtl/u8d_decode.sv
// Decoder: sequence state, per-byte decode and the response register.
`default_nettype none

module u8d_decode
   import u8d_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire in_word_type word,
   output logic       take,
   u8d_rsp_if.source  rsp_chan
);

   logic [PEND_W-1:0]    pend_ff, pend_in;
   logic [PARTIAL_W-1:0] part_ff, part_in;
   logic                 disc_ff, disc_in;

   logic                 out_valid_ff, out_valid_in;
   logic [CP_W-1:0]      cp_ff, cp_in;
   logic                 err_ff, err_in;
   logic                 done_ff, done_in;

   logic                 emit;
   logic [CP_W-1:0]      wide;
   logic [PEND_W-1:0]    pend_dec;
   logic [BYTE_W-1:0]    b;
   logic                 eos;

   assign take = word.valid && (!out_valid_ff || rsp_chan.ready);
   assign b    = word.in_byte;
   assign eos  = word.end_of_string;
   assign wide = {part_ff, b[CONT_W-1:0]};
   assign pend_dec = pend_ff - PEND_ONE;

   always_comb begin
      emit    = 1'b0;
      cp_in   = '0;
      err_in  = 1'b0;
      done_in = eos;
      pend_in = pend_ff;
      part_in = part_ff;
      disc_in = disc_ff;
      if (disc_ff) begin
         if (eos) begin
            disc_in = 1'b0;
         end
      end else if (pend_ff != PEND_NONE) begin
         pend_in = pend_dec;
         if (pend_dec == PEND_NONE) begin
            part_in = '0;
            emit    = 1'b1;
            cp_in   = wide;
         end else if (eos) begin
            // truncated mid-sequence
            pend_in = PEND_NONE;
            part_in = '0;
            emit    = 1'b1;
            err_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            part_in = wide[PARTIAL_W-1:0];
         end
      end else if (!b[BYTE_W-1]) begin
         emit  = 1'b1;
         cp_in = {{(CP_W-BYTE_W+1){1'b0}}, b[BYTE_W-2:0]};
      end else if (b < LEAD_2_LO || b > LEAD_4_HI || eos) begin
         // stray continuation, bad lead, or lead on the last byte
         pend_in = PEND_NONE;
         part_in = '0;
         disc_in = !eos;
         emit    = 1'b1;
         err_in  = 1'b1;
         done_in = 1'b1;
      end else if (b <= LEAD_2_HI) begin
         pend_in = PEND_ONE;
         part_in = {{(PARTIAL_W-5){1'b0}}, b[4:0]};
      end else if (b <= LEAD_3_HI) begin
         pend_in = PEND_TWO;
         part_in = {{(PARTIAL_W-4){1'b0}}, b[3:0]};
      end else begin
         pend_in = PEND_THREE;
         part_in = {{(PARTIAL_W-3){1'b0}}, b[2:0]};
      end
   end

   assign out_valid_in = (take && emit) || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= PEND_NONE;
         part_ff      <= '0;
         disc_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            pend_ff <= pend_in;
            part_ff <= part_in;
            disc_ff <= disc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         cp_ff   <= cp_in;
         err_ff  <= err_in;
         done_ff <= done_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.code_point  = cp_ff;
   assign rsp_chan.error       = err_ff;
   assign rsp_chan.string_done = done_ff;

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// Top level: streaming UTF-8 byte to code point decoder.
//
//   channel    dir  payload                               word
//   req_chan   in   in_byte[7:0], end_of_string           one string byte
//   rsp_chan   out  code_point[20:0], error, string_done  zero or one per byte
//
// One byte per clock sustained while rsp_chan.ready holds; an accepted byte passes
// through the input register, and its result, if any, into the response register.
// Synchronous reset clears the sequence state and both valid flags.
// A stalled response holds the decoder; the input register then holds one byte
// and req_chan.ready follows rsp_chan.ready.
`default_nettype none

module utf8_stream_decoder
   import u8d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   u8d_req_if.sink   req_chan,
   u8d_rsp_if.source rsp_chan
);

   in_word_type word;
   logic        take;

   u8d_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .word     (word)
   );

   u8d_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .word     (word),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sim/utf8_stream_decoder_tb.sv
// Testbench: UTF-8 stream decoder, directed strings then random traffic against a predictor.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb
   import u8d_pkg::*;
();

   localparam int STALL_PCT      = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            error;
      logic            string_done;
   } cp_word_type;

   logic clock = 1'b0;
   logic reset;

   u8d_req_if req_if ();
   u8d_rsp_if rsp_if ();

   utf8_stream_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [PEND_W-1:0]    pend_cnt;
   logic [PARTIAL_W-1:0] partial_cp;
   logic                 dropping;

   cp_word_type expected_cp[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   bit          steady = 1'b0;

   // Returns 1 when the byte yields a word, placed in word.
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eos,
                                      output cp_word_type word);
      logic [CP_W-1:0] wide;
      bit              bad;
      word = '0;
      bad  = 1'b0;
      if (dropping) begin
         if (eos) dropping = 1'b0;
         return 1'b0;
      end
      if (pend_cnt != PEND_NONE) begin
         wide     = {partial_cp, b[CONT_W-1:0]};
         pend_cnt = pend_cnt - 1'b1;
         if (pend_cnt == PEND_NONE) begin
            partial_cp       = '0;
            word.code_point  = wide;
            word.string_done = eos;
            return 1'b1;
         end
         if (!eos) begin
            partial_cp = wide[PARTIAL_W-1:0];
            return 1'b0;
         end
         bad = 1'b1;
      end else if (!b[7]) begin
         word.code_point  = CP_W'(b);
         word.string_done = eos;
         return 1'b1;
      end else if (b < LEAD_2_LO || b > LEAD_4_HI || eos) begin
         bad = 1'b1;
      end else if (b <= LEAD_2_HI) begin
         pend_cnt   = PEND_ONE;
         partial_cp = PARTIAL_W'(b[4:0]);
      end else if (b <= LEAD_3_HI) begin
         pend_cnt   = PEND_TWO;
         partial_cp = PARTIAL_W'(b[3:0]);
      end else begin
         pend_cnt   = PEND_THREE;
         partial_cp = PARTIAL_W'(b[2:0]);
      end
      if (bad) begin
         pend_cnt         = PEND_NONE;
         partial_cp       = '0;
         dropping         = !eos;
         word.error       = 1'b1;
         word.string_done = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      cp_word_type word;
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.in_byte       <= b;
      req_if.end_of_string <= eos;
      do @(posedge clock); while (!req_if.ready);
      if (decode_byte(b, eos, word)) expected_cp = {expected_cp, word};
      bytes_sent++;
   endtask

   task automatic test_ascii_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b1);
   endtask

   // 2-, 3- and 4-byte sequences at the lead range limits; continuation bits unchecked
   task automatic test_sequences();
      send_byte(8'hc0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hdf, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b1);
      send_byte(8'hf7, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h3f, 1'b0);
      send_byte(8'hc0, 1'b1);
   endtask

   task automatic test_bad_leads();
      send_byte(8'h80, 1'b1);
      send_byte(8'hbf, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'hf8, 1'b0);
      send_byte(8'hff, 1'b1);
   endtask

   task automatic test_truncation();
      send_byte(8'hc3, 1'b1);
      send_byte(8'he2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'h24, 1'b1);
   endtask

   // well-formed strings with random content, some noise and cut-short strings
   task automatic test_random_strings(input int n_bytes, input bit gapless);
      logic [BYTE_W-1:0] str[$];
      logic [CP_W-1:0]   cp;
      int                n_chars, len, cut, stop_at, c, i;
      steady  = gapless;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         str.delete();
         n_chars = $urandom_range(1, 6);
         for (c = 0; c < n_chars; c++) begin
            cp  = CP_W'($urandom);
            len = $urandom_range(1, 4);
            if ($urandom_range(99) < 8) begin
               str = {str, BYTE_W'($urandom_range(255))};
            end else begin
               case (len)
                  1: str = {str, {1'b0, cp[6:0]}};
                  2: begin
                     str = {str, {3'b110, cp[10:6]}};
                     str = {str, {2'b10, cp[5:0]}};
                  end
                  3: begin
                     str = {str, {4'b1110, cp[15:12]}};
                     str = {str, {2'b10, cp[11:6]}};
                     str = {str, {2'b10, cp[5:0]}};
                  end
                  default: begin
                     str = {str, {5'b11110, cp[20:18]}};
                     str = {str, {2'b10, cp[17:12]}};
                     str = {str, {2'b10, cp[11:6]}};
                     str = {str, {2'b10, cp[5:0]}};
                  end
               endcase
            end
         end
         if (str.size() > 1 && $urandom_range(99) < 6) begin
            cut = $urandom_range(1, str.size() - 1);
            while (str.size() > cut) void'(str.pop_back());
         end
         for (i = 0; i < str.size(); i++) send_byte(str[i], i == str.size() - 1);
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin : check_words
      cp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_cp.size() == 0) begin
            $error("unexpected word: code_point %h error %b string_done %b",
                   rsp_if.code_point, rsp_if.error, rsp_if.string_done);
            fail_count++;
         end else begin
            want = expected_cp.pop_front();
            if (rsp_if.code_point !== want.code_point) begin
               $error("code_point: expected %h, got %h", want.code_point, rsp_if.code_point);
               fail_count++;
            end
            if (rsp_if.error !== want.error) begin
               $error("error: expected %b, got %b", want.error, rsp_if.error);
               fail_count++;
            end
            if (rsp_if.string_done !== want.string_done) begin
               $error("string_done: expected %b, got %b", want.string_done,
                      rsp_if.string_done);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      pend_cnt             = PEND_NONE;
      partial_cp           = '0;
      dropping             = 1'b0;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.in_byte       <= '0;
      req_if.end_of_string <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii_extremes();
      test_sequences();
      test_bad_leads();
      test_truncation();
      test_random_strings(700, 1'b0);
      test_random_strings(300, 1'b1);
      test_random_strings(700, 1'b0);

      req_if.valid <= 1'b0;
      while (expected_cp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/u8d_in_stage.sv
rtl/u8d_decode.sv
rtl/utf8_stream_decoder.sv
sim/utf8_stream_decoder_tb.sv
